@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked away from reset.
`define AST_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked away from reset.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is checked during reset too.
`define AST_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/ttc_pkg.sv @@
package ttc_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int LANES         = 5;
    // Partial remainders stay below eight times a 36-bit denominator.
    localparam int RW            = 40;

    localparam logic signed [31:0] OVL_RESET = -32'sd32768;
    localparam logic [16:0]        LOW_RESET = 17'd655;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_OVERLOAD   = 2'd1;
    localparam logic [1:0] ST_LOWLIGHT   = 2'd2;
    localparam logic [1:0] ST_DEGENERATE = 2'd3;

    localparam logic CFG_OVERLOAD = 1'b0;
    localparam logic CFG_LOWLIGHT = 1'b1;

    localparam int L_X  = 0;
    localparam int L_Y  = 1;
    localparam int L_U  = 2;
    localparam int L_V  = 3;
    localparam int L_V6 = 4;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [RW-1:0] dvs;
    } t_lane;

endpackage

@@ hw/rtl/ttc_front.sv @@
module ttc_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic signed [31:0]                    i_tri_x,
    input  logic signed [31:0]                    i_tri_y,
    input  logic signed [31:0]                    i_tri_z,
    input  logic signed [31:0]                    i_ovl_thr,
    input  logic [16:0]                           i_low_thr,
    output logic                                  o_valid,
    output logic [1:0]                            o_status,
    output ttc_pkg::t_lane [ttc_pkg::LANES-1:0]   o_lane
);
    import ttc_pkg::*;

    logic signed [33:0] n_sum;
    logic signed [36:0] n_den;
    logic signed [36:0] w_lt;
    logic [1:0]         n_status;
    t_lane [LANES-1:0]  n_lane;
    logic [RW-1:0]      w_ux;
    logic [RW-1:0]      w_uy;
    logic [RW-1:0]      w_sum;
    logic [RW-1:0]      w_den;

    logic                r_valid;
    logic [1:0]          r_status;
    t_lane [LANES-1:0]   r_lane;

    always_comb begin
        w_lt  = 37'($signed({1'b0, i_low_thr}));
        n_sum = 34'(i_tri_x) + 34'(i_tri_y) + 34'(i_tri_z);
        n_den = 37'(i_tri_x) + (37'(i_tri_y) <<< 4) - 37'(i_tri_y)
              + (37'(i_tri_z) <<< 1) + 37'(i_tri_z);
        if (i_tri_x < i_ovl_thr) begin
            n_status = ST_OVERLOAD;
        end else if (37'(i_tri_x) < w_lt || 37'(i_tri_y) < w_lt || 37'(i_tri_z) < w_lt) begin
            n_status = ST_LOWLIGHT;
        end else if (!(37'(n_sum) > w_lt && n_den > w_lt)) begin
            n_status = ST_DEGENERATE;
        end else begin
            n_status = ST_OK;
        end
        // Operands only matter on an ok request, where everything is non-negative.
        w_ux  = RW'(unsigned'(i_tri_x));
        w_uy  = RW'(unsigned'(i_tri_y));
        w_sum = RW'(unsigned'(n_sum));
        w_den = RW'(unsigned'(n_den));
        n_lane[L_X].rem  = w_ux;
        n_lane[L_Y].rem  = w_uy;
        n_lane[L_U].rem  = w_ux << 2;
        n_lane[L_V].rem  = (w_uy << 3) + w_uy;
        n_lane[L_V6].rem = (w_uy << 2) + (w_uy << 1);
        n_lane[L_X].dvs  = w_sum << 2;
        n_lane[L_Y].dvs  = w_sum << 2;
        n_lane[L_U].dvs  = w_den << 2;
        n_lane[L_V].dvs  = w_den << 2;
        n_lane[L_V6].dvs = w_den << 2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_status <= n_status;
            r_lane   <= n_lane;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_lane   = r_lane;

endmodule

@@ hw/rtl/ttc_div_cell.sv @@
module ttc_div_cell #(
    parameter int QW = ttc_pkg::DEF_FRAC_BITS + 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [1:0]                            i_status,
    input  ttc_pkg::t_lane [ttc_pkg::LANES-1:0]   i_lane,
    input  logic [ttc_pkg::LANES-1:0][QW-1:0]     i_quo,
    output logic                                  o_valid,
    output logic [1:0]                            o_status,
    output ttc_pkg::t_lane [ttc_pkg::LANES-1:0]   o_lane,
    output logic [ttc_pkg::LANES-1:0][QW-1:0]     o_quo
);
    import ttc_pkg::*;

    t_lane [LANES-1:0]         n_lane;
    logic [LANES-1:0][QW-1:0]  n_quo;
    logic [LANES-1:0]          w_ge;

    logic                      r_valid;
    logic [1:0]                r_status;
    t_lane [LANES-1:0]         r_lane;
    logic [LANES-1:0][QW-1:0]  r_quo;

    // One restoring step per lane: the remainder stays below twice the divisor.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_ge[l]       = i_lane[l].rem >= i_lane[l].dvs;
            n_lane[l].dvs = i_lane[l].dvs;
            n_lane[l].rem = (w_ge[l] ? i_lane[l].rem - i_lane[l].dvs : i_lane[l].rem) << 1;
            n_quo[l]      = {i_quo[l][QW-2:0], w_ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_status <= i_status;
            r_lane   <= n_lane;
            r_quo    <= n_quo;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_lane   = r_lane;
    assign o_quo    = r_quo;

endmodule

@@ hw/rtl/tristimulus_to_chromaticity_unit.sv @@
// Converts a signed Q16.16 XYZ triple into x, y, u', v' and 1960 v with a status.
// A new request is taken every cycle unless o_stall is high; each result passes
// through one check stage, FRAC_BITS + 3 division cells and one output register,
// in that order, the divider being a chain of one-bit cells.
// A stall while a result is waiting freezes the whole chain and is reflected on o_stall.
module tristimulus_to_chromaticity_unit #(
    parameter int FRAC_BITS = ttc_pkg::DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_tri_x,
    input  logic signed [31:0] i_tri_y,
    input  logic signed [31:0] i_tri_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [16:0]        o_chroma_x,
    output logic [16:0]        o_chroma_y,
    output logic [17:0]        o_u_prime,
    output logic [15:0]        o_v_prime,
    output logic [14:0]        o_v_1960,
    output logic [1:0]         o_status,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    import ttc_pkg::*;

    localparam int QW = FRAC_BITS + 3;

    logic                       w_en;
    logic                       w_valid  [0:QW];
    logic [1:0]                 w_status [0:QW];
    t_lane [LANES-1:0]          w_lane   [0:QW];
    logic [LANES-1:0][QW-1:0]   w_quo    [0:QW];
    logic [LANES-1:0][63:0]     w_qe;

    logic signed [31:0] r_ovl_thr;
    logic [16:0]        r_low_thr;
    logic               r_valid;
    logic [1:0]         r_status;
    logic [16:0]        r_chroma_x;
    logic [16:0]        r_chroma_y;
    logic [17:0]        r_u_prime;
    logic [15:0]        r_v_prime;
    logic [14:0]        r_v_1960;
    logic [16:0]        n_chroma_x;
    logic [16:0]        n_chroma_y;
    logic [17:0]        n_u_prime;
    logic [15:0]        n_v_prime;
    logic [14:0]        n_v_1960;

    assign w_en    = !(r_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovl_thr <= OVL_RESET;
            r_low_thr <= LOW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OVERLOAD: r_ovl_thr <= i_cfg_data;
                CFG_LOWLIGHT: r_low_thr <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    ttc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_valid),
        .i_tri_x   (i_tri_x),
        .i_tri_y   (i_tri_y),
        .i_tri_z   (i_tri_z),
        .i_ovl_thr (r_ovl_thr),
        .i_low_thr (r_low_thr),
        .o_valid   (w_valid[0]),
        .o_status  (w_status[0]),
        .o_lane    (w_lane[0])
    );

    assign w_quo[0] = '0;

    for (genvar g = 0; g < QW; g++) begin : g_cell
        ttc_div_cell #(.QW(QW)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_valid  (w_valid[g]),
            .i_status (w_status[g]),
            .i_lane   (w_lane[g]),
            .i_quo    (w_quo[g]),
            .o_valid  (w_valid[g+1]),
            .o_status (w_status[g+1]),
            .o_lane   (w_lane[g+1]),
            .o_quo    (w_quo[g+1])
        );
    end

    // Saturate each quotient to its field; any error forces zeros.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_qe[l] = 64'(w_quo[QW][l]);
        end
        n_chroma_x = (|(w_qe[L_X]  >> 17)) ? '1 : w_qe[L_X][16:0];
        n_chroma_y = (|(w_qe[L_Y]  >> 17)) ? '1 : w_qe[L_Y][16:0];
        n_u_prime  = (|(w_qe[L_U]  >> 18)) ? '1 : w_qe[L_U][17:0];
        n_v_prime  = (|(w_qe[L_V]  >> 16)) ? '1 : w_qe[L_V][15:0];
        n_v_1960   = (|(w_qe[L_V6] >> 15)) ? '1 : w_qe[L_V6][14:0];
        if (w_status[QW] != ST_OK) begin
            n_chroma_x = '0;
            n_chroma_y = '0;
            n_u_prime  = '0;
            n_v_prime  = '0;
            n_v_1960   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_valid[QW];
        end
        if (w_en) begin
            r_status   <= w_status[QW];
            r_chroma_x <= n_chroma_x;
            r_chroma_y <= n_chroma_y;
            r_u_prime  <= n_u_prime;
            r_v_prime  <= n_v_prime;
            r_v_1960   <= n_v_1960;
        end
    end

    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_chroma_x = r_chroma_x;
    assign o_chroma_y = r_chroma_y;
    assign o_u_prime  = r_u_prime;
    assign o_v_prime  = r_v_prime;
    assign o_v_1960   = r_v_1960;

endmodule

@@ hw/rtl/ttc_checker.sv @@
`include "assert_macros.svh"

module ttc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [16:0] o_chroma_x,
    input logic [16:0] o_chroma_y,
    input logic [17:0] o_u_prime,
    input logic [15:0] o_v_prime,
    input logic [14:0] o_v_1960,
    input logic [1:0]  o_status
);
    import ttc_pkg::*;

    logic w_all_zero;

    assign w_all_zero = o_chroma_x == '0 && o_chroma_y == '0 && o_u_prime == '0
                     && o_v_prime == '0 && o_v_1960 == '0;

    // An errored result carries no ratios.
    `AST_IMPLIES(a_err_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK, w_all_zero)

    // The input side is only held back by a result that is waiting.
    `AST_IMPLIES(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // A waiting result stays put (its status, x and u' are compared).
    `AST_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_chroma_x) && $stable(o_u_prime))

    // Nothing is offered straight after a reset cycle.
    `AST_ALWAYS(a_reset, i_clk, !i_rst_n, !o_valid)

endmodule

bind tristimulus_to_chromaticity_unit ttc_checker u_ttc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_chroma_x (o_chroma_x),
    .o_chroma_y (o_chroma_y),
    .o_u_prime  (o_u_prime),
    .o_v_prime  (o_v_prime),
    .o_v_1960   (o_v_1960),
    .o_status   (o_status)
);

@@ test/tb_tristimulus_to_chromaticity_unit.sv @@
module tb_tristimulus_to_chromaticity_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ttc_pkg::*;

    localparam int LATENCY     = DEF_FRAC_BITS + 5;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [16:0] cx;
        logic [16:0] cy;
        logic [17:0] u;
        logic [15:0] v;
        logic [14:0] v6;
        logic [1:0]  st;
    } t_chroma;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_tri_x = '0;
    logic signed [31:0] i_tri_y = '0;
    logic signed [31:0] i_tri_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [16:0]        o_chroma_x;
    logic [16:0]        o_chroma_y;
    logic [17:0]        o_u_prime;
    logic [15:0]        o_v_prime;
    logic [14:0]        o_v_1960;
    logic [1:0]         o_status;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = CFG_OVERLOAD;
    logic [31:0]        i_cfg_data = '0;

    tristimulus_to_chromaticity_unit u_top (.*);

    always #10 i_clk = ~i_clk;

    // Shadow copies of the thresholds as the block holds them.
    logic signed [31:0] ovl_thr = OVL_RESET;
    logic [16:0]        low_thr = LOW_RESET;

    t_chroma chroma_due[$];
    int      errors = 0;
    int      cycles = 0;
    int      burst_left = 0;

    function automatic longint unsigned scaled_ratio(longint unsigned num,
                                                     longint unsigned den, int width);
        longint unsigned q;
        longint unsigned maxv;
        maxv = (64'd1 << width) - 1;
        q = (num << DEF_FRAC_BITS) / den;
        return (q > maxv) ? maxv : q;
    endfunction

    function automatic t_chroma predict_chroma(logic signed [31:0] tx,
                                               logic signed [31:0] ty,
                                               logic signed [31:0] tz);
        t_chroma r;
        longint x, y, z, lt, sum, den;
        x = tx;
        y = ty;
        z = tz;
        lt = longint'({15'd0, low_thr});
        sum = x + y + z;
        den = x + 15 * y + 3 * z;
        r = '0;
        if (x < longint'(ovl_thr)) begin
            r.st = ST_OVERLOAD;
        end else if (x < lt || y < lt || z < lt) begin
            r.st = ST_LOWLIGHT;
        end else if (!(sum > lt && den > lt)) begin
            r.st = ST_DEGENERATE;
        end else begin
            r.st = ST_OK;
            r.cx = 17'(scaled_ratio(x, sum, 17));
            r.cy = 17'(scaled_ratio(y, sum, 17));
            r.u  = 18'(scaled_ratio(4 * x, den, 18));
            r.v  = 16'(scaled_ratio(9 * y, den, 16));
            r.v6 = 15'(scaled_ratio(6 * y, den, 15));
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver stalls follow a randomly drawn mode: none, rare, frequent or periodic.
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= cycles[2];
        endcase
    end

    always @(posedge i_clk) begin
        t_chroma want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (chroma_due.size() == 0) begin
                report_mismatch("unexpected result", o_status, -1);
            end else begin
                want = chroma_due.pop_front();
                if (o_status !== want.st) report_mismatch("status", o_status, want.st);
                if (o_chroma_x !== want.cx) report_mismatch("chroma_x", o_chroma_x, want.cx);
                if (o_chroma_y !== want.cy) report_mismatch("chroma_y", o_chroma_y, want.cy);
                if (o_u_prime !== want.u) report_mismatch("u_prime", o_u_prime, want.u);
                if (o_v_prime !== want.v) report_mismatch("v_prime", o_v_prime, want.v);
                if (o_v_1960 !== want.v6) report_mismatch("v_1960", o_v_1960, want.v6);
            end
        end
    end

    // Sends one request; returns just after the edge that accepted it.
    task automatic send_triple(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_tri_x <= x;
        i_tri_y <= y;
        i_tri_z <= z;
        do @(posedge i_clk); while (o_stall);
        chroma_due.push_back(predict_chroma(x, y, z));
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (chroma_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_OVERLOAD) ovl_thr = data;
        else low_thr = data[16:0];
    endtask

    // A component at or above the lowlight threshold, of random magnitude.
    function automatic logic signed [31:0] bright_value();
        longint v;
        v = longint'(low_thr) + ($urandom() >> $urandom_range(1, 24));
        return (v > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF : v[31:0];
    endfunction

    task automatic test_default_thresholds;
        send_triple(32'sd65536, 32'sd65536, 32'sd65536);
        send_triple(32'sd0, 32'sd0, 32'sd0);
        send_triple(-32'sd32769, 32'sd65536, 32'sd65536);
        send_triple(-32'sd32768, 32'sd65536, 32'sd65536);
        send_triple(32'sd655, 32'sd655, 32'sd654);
        send_triple(32'sd655, 32'sd655, 32'sd655);
        send_triple(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_triple(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_triple(32'sh7FFF_FFFF, 32'sd655, 32'sd655);
        send_triple(32'sd655, 32'sh7FFF_FFFF, 32'sd655);
        send_triple(32'sd655, 32'sd655, 32'sh7FFF_FFFF);
    endtask

    task automatic test_threshold_extremes;
        // With a zero lowlight threshold, X alone gives u' = 4, which saturates.
        write_reg(CFG_LOWLIGHT, 32'd0);
        write_reg(CFG_OVERLOAD, 32'd0);
        send_triple(32'sd1000, 32'sd0, 32'sd0);
        send_triple(32'sd0, 32'sd0, 32'sd0);
        send_triple(32'sd0, 32'sd1, 32'sd0);
        send_triple(32'sd0, 32'sd0, 32'sd1);
        send_triple(-32'sd1, 32'sd5, 32'sd5);
        write_reg(CFG_LOWLIGHT, 32'd65536);
        write_reg(CFG_OVERLOAD, 32'h8000_0000);
        send_triple(32'sh8000_0000, 32'sd65536, 32'sd65536);
        send_triple(32'sd65536, 32'sd65536, 32'sd65536);
        send_triple(32'sd65535, 32'sd65536, 32'sd65536);
        write_reg(CFG_LOWLIGHT, 32'hFFFF_FFFF);
        send_triple(32'sd131071, 32'sd131071, 32'sd131071);
        send_triple(32'sd131070, 32'sd131071, 32'sd131071);
    endtask

    task automatic test_random_traffic;
        int phase;
        int n;
        logic signed [31:0] x, y, z;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_OVERLOAD, OVL_RESET);
                    write_reg(CFG_LOWLIGHT, LOW_RESET);
                end
                1: begin
                    write_reg(CFG_OVERLOAD, 32'd0);
                    write_reg(CFG_LOWLIGHT, 32'd0);
                end
                2: begin
                    write_reg(CFG_OVERLOAD, 32'h8000_0000);
                    write_reg(CFG_LOWLIGHT, 32'd65536);
                end
                default: begin
                    write_reg(CFG_OVERLOAD, $urandom());
                    write_reg(CFG_LOWLIGHT, $urandom());
                end
            endcase
            for (n = 0; n < 140; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    x = $urandom();
                    y = $urandom();
                    z = $urandom();
                end else begin
                    x = bright_value();
                    y = bright_value();
                    z = bright_value();
                    // Occasional nudges across the thresholds.
                    case ($urandom_range(0, 9))
                        0: x = ovl_thr - $urandom_range(0, 2);
                        1: y = $signed({15'd0, low_thr}) - $urandom_range(0, 1);
                        2: z = $signed({15'd0, low_thr}) - $urandom_range(0, 1);
                        3: begin
                            y = 0;
                            z = 0;
                        end
                        default: ;
                    endcase
                end
                send_triple(x, y, z);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_thresholds();
        test_threshold_extremes();
        test_random_traffic();
        drain();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
